// ===== rtl/tbr_pkg.sv =====
// ----------------------------------------------------------------------------
// tbr_pkg - shared definitions for the triangle bounding-box rasteriser
// Coordinate widths, arithmetic widths for the edge tests, register indexes
// and the stage word passed between the pipeline registers.
// ----------------------------------------------------------------------------
package tbr_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 32;
    localparam int DIFF_W     = COORD_BITS + 1;    // signed vertex difference
    localparam int PROD_W     = 2 * DIFF_W;        // signed product of two differences
    localparam int EDGE_W     = PROD_W + 1;        // difference of two products
    localparam int SUM_W      = PROD_W + 3;        // z - a - b

    localparam int CFG_IDX_W  = 3;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 56;
    localparam int M_USER_W   = 2;

    typedef logic [COORD_BITS-1:0]    coord_t;
    typedef logic [COLOR_BITS-1:0]    color_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [EDGE_W-1:0] edge_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERT0_X    = 3'd0,
        REG_VERT0_Y    = 3'd1,
        REG_VERT1_X    = 3'd2,
        REG_VERT1_Y    = 3'd3,
        REG_VERT2_X    = 3'd4,
        REG_VERT2_Y    = 3'd5,
        REG_DRAW_COLOR = 3'd6
    } cfg_reg_t;

    // Word held between the product stage and the result stage
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   visit;
        logic   last;
        prod_t  a_pos;
        prod_t  a_neg;
        prod_t  b_pos;
        prod_t  b_neg;
        prod_t  z_pos;
        prod_t  z_neg;
    } prod_word_t;

endpackage

// ===== rtl/triangle_bbox_rasterizer.sv =====
// ----------------------------------------------------------------------------
// triangle_bbox_rasterizer - bounding-box triangle scan with edge-function test
// Walks the bounding box of three configured vertices, x outer and y inner,
// and reports every position with its colour and an inside-or-on-edge flag.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  --------------------------------------
//  s_       in         s_tvalid / s_tready  tdata: start_req
//  m_       out        m_tvalid / m_tready  tdata: x, y, colour; tuser: covered,
//                                           degenerate; tlast: last position
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
//  One word is accepted per cycle while s_tready is high; each gives one result word.
//  Each word passes the product register, then the result register; the scan
//  counters update in the cycle a word is accepted, so words follow back to back.
//  Reset (aresetn low, synchronous) clears registers, scan state and both stages.
//  A stall on m_ fills the result register, then the product stage, then
//  drops s_tready; no word is lost or repeated.
//
module triangle_bbox_rasterizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tbr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tbr_pkg::S_DATA_W-1:0]  s_tdata,   // [0] start_req, rest zero
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tbr_pkg::M_DATA_W-1:0]  m_tdata,   // [11:0] pixel_x, [23:12] pixel_y,
                                                     // [55:24] pixel_color
    output logic                          m_tlast,   // last
    output logic [tbr_pkg::M_USER_W-1:0]  m_tuser    // [0] covered, [1] degenerate
);

    // ---------------- configuration registers ----------------
    tbr_pkg::coord_t v0x_reg, v0y_reg, v1x_reg, v1y_reg, v2x_reg, v2y_reg;
    tbr_pkg::color_t color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0x_reg   <= '0;
            v0y_reg   <= '0;
            v1x_reg   <= '0;
            v1y_reg   <= '0;
            v2x_reg   <= '0;
            v2y_reg   <= '0;
            color_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (tbr_pkg::cfg_reg_t'(cfg_index))
                tbr_pkg::REG_VERT0_X:    v0x_reg   <= cfg_data[tbr_pkg::COORD_BITS-1:0];
                tbr_pkg::REG_VERT0_Y:    v0y_reg   <= cfg_data[tbr_pkg::COORD_BITS-1:0];
                tbr_pkg::REG_VERT1_X:    v1x_reg   <= cfg_data[tbr_pkg::COORD_BITS-1:0];
                tbr_pkg::REG_VERT1_Y:    v1y_reg   <= cfg_data[tbr_pkg::COORD_BITS-1:0];
                tbr_pkg::REG_VERT2_X:    v2x_reg   <= cfg_data[tbr_pkg::COORD_BITS-1:0];
                tbr_pkg::REG_VERT2_Y:    v2y_reg   <= cfg_data[tbr_pkg::COORD_BITS-1:0];
                tbr_pkg::REG_DRAW_COLOR: color_reg <= cfg_data[tbr_pkg::COLOR_BITS-1:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_ready;
    logic s1_ready;
    logic accept;

    assign out_ready = !m_valid_reg || m_tready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s_tready  = s1_ready;
    assign accept    = s_tvalid && s_tready;

    // ---------------- scan state ----------------
    tbr_pkg::coord_t scan_x_reg, scan_y_reg, scan_x_next, scan_y_next;
    tbr_pkg::coord_t bx_min_reg, bx_max_reg, by_min_reg, by_max_reg;
    tbr_pkg::coord_t bx_min_next, bx_max_next, by_min_next, by_max_next;
    logic            active_reg, active_next;
    logic            visit, is_last;
    logic            start_req;

    assign start_req = s_tdata[0];

    function automatic tbr_pkg::coord_t min3(tbr_pkg::coord_t a, tbr_pkg::coord_t b,
                                             tbr_pkg::coord_t c);
        tbr_pkg::coord_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic tbr_pkg::coord_t max3(tbr_pkg::coord_t a, tbr_pkg::coord_t b,
                                             tbr_pkg::coord_t c);
        tbr_pkg::coord_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    always_comb begin
        scan_x_next = scan_x_reg;
        scan_y_next = scan_y_reg;
        bx_min_next = bx_min_reg;
        bx_max_next = bx_max_reg;
        by_min_next = by_min_reg;
        by_max_next = by_max_reg;
        active_next = active_reg;
        visit       = 1'b0;
        is_last     = 1'b0;
        if (accept) begin
            if (start_req) begin
                // latch the box and jump to its lower corner
                bx_min_next = min3(v0x_reg, v1x_reg, v2x_reg);
                bx_max_next = max3(v0x_reg, v1x_reg, v2x_reg);
                by_min_next = min3(v0y_reg, v1y_reg, v2y_reg);
                by_max_next = max3(v0y_reg, v1y_reg, v2y_reg);
                scan_x_next = bx_min_next;
                scan_y_next = by_min_next;
                active_next = 1'b1;
                visit       = 1'b1;
            end else if (active_reg) begin
                // advance y, wrap to the next column at the box top
                if (scan_y_reg < by_max_reg) begin
                    scan_y_next = scan_y_reg + 1'b1;
                end else begin
                    scan_y_next = by_min_reg;
                    scan_x_next = scan_x_reg + 1'b1;
                end
                visit = 1'b1;
            end
            if (visit) begin
                is_last = (scan_x_next >= bx_max_next) && (scan_y_next >= by_max_next);
                if (is_last) begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_x_reg <= '0;
            scan_y_reg <= '0;
            bx_min_reg <= '0;
            bx_max_reg <= '0;
            by_min_reg <= '0;
            by_max_reg <= '0;
            active_reg <= 1'b0;
        end else begin
            scan_x_reg <= scan_x_next;
            scan_y_reg <= scan_y_next;
            bx_min_reg <= bx_min_next;
            bx_max_reg <= bx_max_next;
            by_min_reg <= by_min_next;
            by_max_reg <= by_max_next;
            active_reg <= active_next;
        end
    end

    // ---------------- product stage ----------------
    // Edge vectors from v0 and the offset of v0 from the visited position
    tbr_pkg::diff_t e1x, e1y, e2x, e2y, dx, dy;
    tbr_pkg::prod_word_t s1_next, s1_reg;

    assign e1x = tbr_pkg::diff_t'({1'b0, v1x_reg}) - tbr_pkg::diff_t'({1'b0, v0x_reg});
    assign e1y = tbr_pkg::diff_t'({1'b0, v1y_reg}) - tbr_pkg::diff_t'({1'b0, v0y_reg});
    assign e2x = tbr_pkg::diff_t'({1'b0, v2x_reg}) - tbr_pkg::diff_t'({1'b0, v0x_reg});
    assign e2y = tbr_pkg::diff_t'({1'b0, v2y_reg}) - tbr_pkg::diff_t'({1'b0, v0y_reg});
    assign dx  = tbr_pkg::diff_t'({1'b0, v0x_reg}) - tbr_pkg::diff_t'({1'b0, scan_x_next});
    assign dy  = tbr_pkg::diff_t'({1'b0, v0y_reg}) - tbr_pkg::diff_t'({1'b0, scan_y_next});

    always_comb begin
        s1_next.pixel_x     = scan_x_next;
        s1_next.pixel_y     = scan_y_next;
        s1_next.pixel_color = color_reg;
        s1_next.visit       = visit;
        s1_next.last        = is_last;
        s1_next.a_pos       = e2x * dy;
        s1_next.a_neg       = dx * e2y;
        s1_next.b_pos       = dx * e1y;
        s1_next.b_neg       = e1x * dy;
        s1_next.z_pos       = e1x * e2y;
        s1_next.z_neg       = e2x * e1y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
    end

    // ---------------- edge test and result register ----------------
    tbr_pkg::edge_t ea, eb, ez;
    tbr_pkg::sum_t  ec;
    logic           degen, inside_pos, inside_neg, cov;

    always_comb begin
        ea = tbr_pkg::edge_t'(s1_reg.a_pos) - tbr_pkg::edge_t'(s1_reg.a_neg);
        eb = tbr_pkg::edge_t'(s1_reg.b_pos) - tbr_pkg::edge_t'(s1_reg.b_neg);
        ez = tbr_pkg::edge_t'(s1_reg.z_pos) - tbr_pkg::edge_t'(s1_reg.z_neg);
        ec = tbr_pkg::sum_t'(ez) - tbr_pkg::sum_t'(ea) - tbr_pkg::sum_t'(eb);
        degen = (ez == '0);
        // positive area: all three non-negative; negative area: all non-positive
        inside_pos = !ez[tbr_pkg::EDGE_W-1] && !ea[tbr_pkg::EDGE_W-1]
                     && !eb[tbr_pkg::EDGE_W-1] && !ec[tbr_pkg::SUM_W-1];
        inside_neg = ez[tbr_pkg::EDGE_W-1]
                     && (ea[tbr_pkg::EDGE_W-1] || ea == '0)
                     && (eb[tbr_pkg::EDGE_W-1] || eb == '0)
                     && (ec[tbr_pkg::SUM_W-1] || ec == '0);
        cov = s1_reg.visit && !degen && (inside_pos || inside_neg);
    end

    tbr_pkg::coord_t m_x_reg, m_y_reg;
    tbr_pkg::color_t m_color_reg;
    logic            m_cov_reg, m_degen_reg, m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s1_valid_reg) begin
            m_x_reg     <= s1_reg.pixel_x;
            m_y_reg     <= s1_reg.pixel_y;
            m_color_reg <= s1_reg.pixel_color;
            m_cov_reg   <= cov;
            m_degen_reg <= degen;
            m_last_reg  <= s1_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_color_reg, m_y_reg, m_x_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_degen_reg, m_cov_reg};

endmodule

// ===== rtl/tbr_checker.sv =====
// ----------------------------------------------------------------------------
// tbr_assertions - port-level checks for the triangle bounding-box rasteriser
// Watches the stream ports and flags coverage, back-pressure, hold and reset slips.
// ----------------------------------------------------------------------------
module tbr_assertions (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tbr_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tlast,
    input logic [tbr_pkg::M_USER_W-1:0]  m_tuser
);

    // a degenerate triangle never reports a covered position
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("covered word flagged degenerate");

    // input back-pressure only arises from a stalled result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // hold a stalled result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result word changed");

endmodule

bind triangle_bbox_rasterizer tbr_assertions u_tbr_assertions (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
